[design/gspe_pkg.sv]
// shared types and constants of the gamepad serial poll engine
// no dependencies; used by the output buffer and the top level
`default_nettype none

package gspe_pkg;

    // controller id that reports analog mode with the lock held
    localparam logic [7:0] ID_ANALOG   = 8'h73;
    localparam logic [7:0] CMD_START   = 8'h01;
    localparam logic [7:0] CMD_POLL    = 8'h42;
    localparam logic [7:0] CMD_CONFIG  = 8'h43;
    localparam logic [7:0] CMD_MODE    = 8'h44;
    localparam logic [7:0] CMD_PAD     = 8'h5A;
    localparam logic [7:0] MODE_LOCK   = 8'h03;

    localparam logic [7:0] STICK_HI    = 8'd192;
    localparam logic [7:0] STICK_LO    = 8'd64;
    localparam logic [7:0] STICK_MID_X = 8'd127;
    localparam logic [7:0] STICK_MID_Y = 8'd128;

    localparam int RX_DEPTH    = 9;
    localparam int SHORT_BYTES = 5;

    // frame sequence: short polls, enter config, analog mode, exit config, read
    localparam logic [2:0] FRM_FIRST = 3'd0;
    localparam logic [2:0] FRM_ENTER = 3'd3;
    localparam logic [2:0] FRM_MODE  = 3'd4;
    localparam logic [2:0] FRM_EXIT  = 3'd5;
    localparam logic [2:0] FRM_READ  = 3'd6;

    // configuration register indexes
    localparam logic CFG_HALF_BIT = 1'b0;
    localparam logic CFG_BYTE_GAP = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_SEL  = 6'b000010,
        PH_HIGH = 6'b000100,
        PH_LOW  = 6'b001000,
        PH_GAP  = 6'b010000,
        PH_END  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic        select_n;
        logic        clock_out;
        logic        command_out;
        logic        frame_done;
        logic [7:0]  device_id;
        logic [15:0] buttons;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [4:0]  pressed_key;
    } t_result;

    function automatic logic stick_edge(input logic [7:0] v);
        return (v > STICK_HI) || (v < STICK_LO);
    endfunction

endpackage

`default_nettype wire

[design/gspe_in_if.sv]
// input channel: one timebase tick with the poll request and the sampled data pin
// no dependencies
`default_nettype none

interface gspe_in_if;
    logic valid;
    logic ready;
    logic poll_request;
    logic data_in;

    modport source (output valid, output poll_request, output data_in, input ready);
    modport sink   (input valid, input poll_request, input data_in, output ready);
endinterface

`default_nettype wire

[design/gspe_out_if.sv]
// output channel: pin levels and the decoded controller report of one tick
// no dependencies
`default_nettype none

interface gspe_out_if;
    logic        valid;
    logic        ready;
    logic        select_n;
    logic        clock_out;
    logic        command_out;
    logic        frame_done;
    logic [7:0]  device_id;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [4:0]  pressed_key;

    modport source (
        output valid, input ready,
        output select_n, output clock_out, output command_out, output frame_done,
        output device_id, output buttons, output right_x, output right_y,
        output left_x, output left_y, output pressed_key
    );
    modport sink (
        input valid, output ready,
        input select_n, input clock_out, input command_out, input frame_done,
        input device_id, input buttons, input right_x, input right_y,
        input left_x, input left_y, input pressed_key
    );
endinterface

`default_nettype wire

[design/gspe_out_buf.sv]
// output register with a skid stage for the result words
// depends on gspe_pkg for the result type
`default_nettype none

module gspe_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  gspe_pkg::t_result      i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output gspe_pkg::t_result      o_data
);

    logic              r_valid;
    logic              r_skid_valid;
    gspe_pkg::t_result r_data;
    gspe_pkg::t_result r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                r_data <= r_skid_data;
            end else if (i_valid) begin
                r_data <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

    // skid stage only fills behind a held output word
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_valid)
        else $error("skid word without output word");

    // a full skid stage blocks new words
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid word lost");

endmodule

`default_nettype wire

[design/gamepad_serial_poll_engine.sv]
// the pin levels and report of a tick leave through the output register of the output buffer
// throughput: one tick per cycle while the output buffer is ready; one sequencer pass per tick
// a held output word is parked in a 2-deep output buffer, so the next tick is still taken
// reset (sync, active low): sequencer idle, configuration needed, received bytes cleared,
// half period 5 ticks, byte gap 16 ticks
`default_nettype none

module gamepad_serial_poll_engine #(
    parameter int FRAME_BYTES = 9
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_idx,
    input  wire [7:0]         i_cfg_data,
    gspe_in_if.sink           i_in,
    gspe_out_if.source        o_out
);

    localparam int BW = $clog2(FRAME_BYTES + 1);
    localparam int TW = 9;

    gspe_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_frame, n_frame;
    logic [BW-1:0]    r_byte, n_byte;
    logic [2:0]       r_bit, n_bit;
    logic [TW-1:0]    r_tick, n_tick;
    logic [7:0]       r_tx, n_tx;
    logic [7:0]       r_rx [gspe_pkg::RX_DEPTH];
    logic [7:0]       n_rx [gspe_pkg::RX_DEPTH];
    logic             r_need_cfg, n_need_cfg;
    logic             r_sample_due, n_sample_due;
    logic [BW-1:0]    r_sample_byte, n_sample_byte;
    logic [2:0]       r_sample_bit, n_sample_bit;
    logic [7:0]       r_half;
    logic [7:0]       r_gap;

    logic              in_acc;
    logic              buf_ready;
    gspe_pkg::t_result res;
    gspe_pkg::t_result out_word;

    function automatic logic [7:0] cmd_byte(input logic [2:0] f, input logic [BW-1:0] b);
        logic [7:0] c;
        c = 8'h00;
        if (int'(b) == 0) begin
            c = gspe_pkg::CMD_START;
        end else if (int'(b) == 1) begin
            if (f < gspe_pkg::FRM_ENTER || f == gspe_pkg::FRM_READ) begin
                c = gspe_pkg::CMD_POLL;
            end else if (f == gspe_pkg::FRM_MODE) begin
                c = gspe_pkg::CMD_MODE;
            end else begin
                c = gspe_pkg::CMD_CONFIG;
            end
        end else if ((f == gspe_pkg::FRM_ENTER || f == gspe_pkg::FRM_MODE) && int'(b) == 3) begin
            c = gspe_pkg::CMD_START;
        end else if (f == gspe_pkg::FRM_MODE && int'(b) == 4) begin
            c = gspe_pkg::MODE_LOCK;
        end else if (f == gspe_pkg::FRM_EXIT && int'(b) >= 4) begin
            c = gspe_pkg::CMD_PAD;
        end
        return c;
    endfunction

    assign i_in.ready = buf_ready;
    assign in_acc     = i_in.valid && buf_ready;

    // sequencer and report for one tick
    always_comb begin
        logic [TW-1:0] half;
        logic [TW-1:0] tick_inc;
        logic [BW:0]   byte_inc;
        logic [BW:0]   flen;
        logic [2:0]    nf;
        logic [15:0]   w;
        logic [7:0]    vrx;
        logic [7:0]    vry;

        n_phase       = r_phase;
        n_frame       = r_frame;
        n_byte        = r_byte;
        n_bit         = r_bit;
        n_tick        = r_tick;
        n_tx          = r_tx;
        n_need_cfg    = r_need_cfg;
        n_sample_due  = 1'b0;
        n_sample_byte = r_sample_byte;
        n_sample_bit  = r_sample_bit;
        for (int j = 0; j < gspe_pkg::RX_DEPTH; j++) begin
            n_rx[j] = r_rx[j];
        end

        half     = (r_half == 8'd0) ? TW'(1) : {1'b0, r_half};
        tick_inc = r_tick + TW'(1);
        byte_inc = {1'b0, r_byte} + (BW+1)'(1);
        flen     = (r_frame < gspe_pkg::FRM_ENTER) ? (BW+1)'(gspe_pkg::SHORT_BYTES)
                                                   : (BW+1)'(FRAME_BYTES);
        nf       = r_frame;
        w        = '0;
        vrx      = '0;
        vry      = '0;

        // data bit latched at the previous clock rise
        if (r_sample_due && i_in.data_in) begin
            for (int j = 0; j < gspe_pkg::RX_DEPTH; j++) begin
                if (int'(r_sample_byte) == j) begin
                    n_rx[j][r_sample_bit] = 1'b1;
                end
            end
        end

        res             = '0;
        res.select_n    = 1'b1;
        res.clock_out   = 1'b1;
        res.command_out = 1'b1;
        if (r_phase == gspe_pkg::PH_SEL || r_phase == gspe_pkg::PH_GAP) begin
            res.select_n = 1'b0;
        end
        if (r_phase == gspe_pkg::PH_HIGH || r_phase == gspe_pkg::PH_LOW) begin
            res.select_n    = 1'b0;
            res.command_out = r_tx[0];
            res.clock_out   = (r_phase != gspe_pkg::PH_LOW);
        end
        if (r_phase == gspe_pkg::PH_END && r_frame == gspe_pkg::FRM_READ) begin
            w   = {n_rx[4], n_rx[3]};
            vrx = n_rx[5];
            vry = n_rx[6];
            if (gspe_pkg::stick_edge(vry)) begin
                vrx = gspe_pkg::STICK_MID_X;
            end
            if (gspe_pkg::stick_edge(vrx)) begin
                vry = gspe_pkg::STICK_MID_Y;
            end
            res.frame_done = 1'b1;
            res.device_id  = n_rx[1];
            res.buttons    = w;
            res.right_x    = vrx;
            res.right_y    = vry;
            res.left_x     = n_rx[7];
            res.left_y     = n_rx[8];
            // lowest zero bit wins
            for (int k = 15; k >= 0; k--) begin
                if (!w[k]) begin
                    res.pressed_key = 5'(k + 1);
                end
            end
        end

        unique case (r_phase)
            gspe_pkg::PH_IDLE: begin
                if (i_in.poll_request) begin
                    nf = r_need_cfg ? gspe_pkg::FRM_FIRST : gspe_pkg::FRM_READ;
                end
            end
            gspe_pkg::PH_SEL: begin
                n_tick = tick_inc;
                if (tick_inc >= {1'b0, r_gap}) begin
                    n_tx    = cmd_byte(r_frame, r_byte);
                    n_bit   = 3'd0;
                    n_phase = gspe_pkg::PH_HIGH;
                    n_tick  = '0;
                end
            end
            gspe_pkg::PH_HIGH: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    n_phase = gspe_pkg::PH_LOW;
                    n_tick  = '0;
                end
            end
            gspe_pkg::PH_LOW: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    n_sample_due  = 1'b1;
                    n_sample_byte = r_byte;
                    n_sample_bit  = r_bit;
                    n_tick        = '0;
                    if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 3'd1;
                        n_tx    = {1'b0, r_tx[7:1]};
                        n_phase = gspe_pkg::PH_HIGH;
                    end else if (r_gap != 8'd0) begin
                        n_phase = gspe_pkg::PH_GAP;
                    end else begin
                        n_byte = byte_inc[BW-1:0];
                        if (byte_inc < flen) begin
                            n_tx    = cmd_byte(r_frame, byte_inc[BW-1:0]);
                            n_bit   = 3'd0;
                            n_phase = gspe_pkg::PH_HIGH;
                        end else begin
                            n_phase = gspe_pkg::PH_END;
                        end
                    end
                end
            end
            gspe_pkg::PH_GAP: begin
                n_tick = tick_inc;
                if (tick_inc >= {1'b0, r_gap}) begin
                    n_byte = byte_inc[BW-1:0];
                    n_tick = '0;
                    if (byte_inc < flen) begin
                        n_tx    = cmd_byte(r_frame, byte_inc[BW-1:0]);
                        n_bit   = 3'd0;
                        n_phase = gspe_pkg::PH_HIGH;
                    end else begin
                        n_phase = gspe_pkg::PH_END;
                    end
                end
            end
            gspe_pkg::PH_END: begin
                if (r_frame == gspe_pkg::FRM_READ) begin
                    n_need_cfg = (n_rx[1] != gspe_pkg::ID_ANALOG);
                    n_phase    = gspe_pkg::PH_IDLE;
                    n_tick     = '0;
                    n_frame    = gspe_pkg::FRM_FIRST;
                    n_byte     = '0;
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc >= ({1'b0, r_gap} + TW'(1))) begin
                        nf = r_frame + 3'd1;
                    end
                end
            end
            default: begin
                n_phase = gspe_pkg::PH_IDLE;
                n_tick  = '0;
            end
        endcase

        // frame start, from idle on a request or after the gap that ends a frame
        if (nf != r_frame || (r_phase == gspe_pkg::PH_IDLE && i_in.poll_request)) begin
            n_frame = nf;
            n_byte  = '0;
            n_tick  = '0;
            if (nf == gspe_pkg::FRM_READ) begin
                for (int j = 0; j < gspe_pkg::RX_DEPTH; j++) begin
                    n_rx[j] = 8'h00;
                end
            end
            if (r_gap == 8'd0) begin
                n_tx    = cmd_byte(nf, '0);
                n_bit   = 3'd0;
                n_phase = gspe_pkg::PH_HIGH;
            end else begin
                n_phase = gspe_pkg::PH_SEL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= gspe_pkg::PH_IDLE;
            r_frame       <= gspe_pkg::FRM_FIRST;
            r_byte        <= '0;
            r_bit         <= 3'd0;
            r_tick        <= '0;
            r_tx          <= 8'h00;
            r_need_cfg    <= 1'b1;
            r_sample_due  <= 1'b0;
            r_sample_byte <= '0;
            r_sample_bit  <= 3'd0;
            for (int j = 0; j < gspe_pkg::RX_DEPTH; j++) begin
                r_rx[j] <= 8'h00;
            end
        end else if (in_acc) begin
            r_phase       <= n_phase;
            r_frame       <= n_frame;
            r_byte        <= n_byte;
            r_bit         <= n_bit;
            r_tick        <= n_tick;
            r_tx          <= n_tx;
            r_need_cfg    <= n_need_cfg;
            r_sample_due  <= n_sample_due;
            r_sample_byte <= n_sample_byte;
            r_sample_bit  <= n_sample_bit;
            for (int j = 0; j < gspe_pkg::RX_DEPTH; j++) begin
                r_rx[j] <= n_rx[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 8'd5;
            r_gap  <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gspe_pkg::CFG_HALF_BIT: r_half <= i_cfg_data;
                gspe_pkg::CFG_BYTE_GAP: r_gap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gspe_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (buf_ready),
        .i_data  (res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_word)
    );

    assign o_out.select_n    = out_word.select_n;
    assign o_out.clock_out   = out_word.clock_out;
    assign o_out.command_out = out_word.command_out;
    assign o_out.frame_done  = out_word.frame_done;
    assign o_out.device_id   = out_word.device_id;
    assign o_out.buttons     = out_word.buttons;
    assign o_out.right_x     = out_word.right_x;
    assign o_out.right_y     = out_word.right_y;
    assign o_out.left_x      = out_word.left_x;
    assign o_out.left_y      = out_word.left_y;
    assign o_out.pressed_key = out_word.pressed_key;

    // a pending data sample is always consumed before the sequencer goes idle
    a_idle_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == gspe_pkg::PH_IDLE) |-> !r_sample_due)
        else $error("sample pending while idle");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= gspe_pkg::FRM_READ)
        else $error("frame index past read frame");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_byte) <= FRAME_BYTES)
        else $error("byte index past frame length");

    // the idle state is left only on an accepted request
    a_start_on_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == gspe_pkg::PH_IDLE && !(in_acc && i_in.poll_request))
            |=> r_phase == gspe_pkg::PH_IDLE)
        else $error("frame started without request");

endmodule

`default_nettype wire
